// ===== hw/rtl/ffca_pkg.sv =====
// ============================================================================
// First-fit chunk allocator package
// Shared types, sizes and codes of the first-fit chunk allocator.
// ============================================================================
`default_nettype none

package ffca_pkg;

    // Region geometry. CHUNK_BYTES is a power of two set by its shift.
    localparam int NUM_CHUNKS  = 1024;
    localparam int CHUNK_SHIFT = 9;
    localparam int CHUNK_BYTES = 1 << CHUNK_SHIFT;

    // Chunk index, and a count that can also hold NUM_CHUNKS itself.
    localparam int IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int CNT_W = $clog2(NUM_CHUNKS + 1);

    // Rounded chunk count of a 32-bit byte size, and the chunk part of an offset.
    localparam int CHUNKS_W = 33 - CHUNK_SHIFT;
    localparam int OFFS_W   = 32 - CHUNK_SHIFT;

    localparam int          BYTES_W    = 20;
    localparam logic [31:0] BASE_RESET = 32'h0060_0000;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_FAIL    = 2'd1,
        STATUS_IGNORED = 2'd2
    } t_status;

    typedef struct packed {
        t_op         operation;
        logic [31:0] size_bytes;
        logic [31:0] address;
    } t_req;

    typedef struct packed {
        logic [31:0]        block_address;
        t_status            status;
        logic [BYTES_W-1:0] vacant_bytes;
        logic [BYTES_W-1:0] occupied_bytes;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_FREE,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/first_fit_chunk_allocator_core.sv =====
// ============================================================================
// First-fit chunk allocator core
// Allocates and frees blocks of whole chunks inside a fixed region, first fit.
// ============================================================================
//
// Usage:
//   Requests arrive on the input channel (i_in_valid / o_in_stall / i_in) and
//   each produces exactly one response on the output channel (o_out_valid /
//   i_out_stall / o_out). A transaction completes on a rising edge where valid
//   is high and stall is low. The base address register is written through
//   i_cfg_valid / o_cfg_ready / i_cfg_data; the user must do so only while no
//   request is in flight, which the core itself does not enforce. Requests are
//   handled one at a time. A rejected allocate or an ignored free goes from
//   decode straight to the output stage. A free first clears its map entry
//   (ST_FREE). An allocate scans the map from the start, one entry at a time
//   through the single read port of the length map: used blocks are hopped
//   over whole, free chunks extend the current run. The next request can be
//   taken in the cycle after the response is placed in the output register.
//   After reset the length map is cleared entry by entry, during which
//   o_in_stall stays high. If the receiver stalls, the response is held in
//   the output register; the core still accepts and processes the next
//   request, and waits to deliver it until the slot frees.
//
// ============================================================================
`default_nettype none

module first_fit_chunk_allocator_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // Request channel
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire ffca_pkg::t_req i_in,
    // Response channel
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ffca_pkg::t_rsp     o_out,
    // Configuration channel: base address
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [31:0]   i_cfg_data
);

    import ffca_pkg::*;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_clr;
    logic [CNT_W-1:0] r_vacant;
    logic [CNT_W-1:0] r_occupied;
    logic [31:0]      r_base;
    logic             r_out_valid;
    t_rsp             r_out;

    t_req             r_req;
    logic [IDX_W-1:0] r_p;      // map index whose data is on the RAM output
    logic [CNT_W-1:0] r_run;    // length of the free run ending before r_p
    logic [CNT_W-1:0] r_len;    // requested length in chunks
    logic [31:0]      r_res_addr;
    t_status          r_res_status;

    // Length map RAM signals
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [CNT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [CNT_W-1:0] ram_rdata;

    // The length map holds, at the first chunk of every block, its length.
    ffca_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_CHUNKS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Decode of the captured request
    // ------------------------------------------------------------------------
    logic [32:0]         size_sum;
    logic [CHUNKS_W-1:0] chunks;
    logic                alloc_bad;
    logic [31:0]         offset;
    logic [OFFS_W-1:0]   free_chunk;
    logic [IDX_W-1:0]    free_idx;
    logic                free_ok;

    // The size is rounded up at full width, so huge sizes never wrap.
    assign size_sum  = {1'b0, r_req.size_bytes} + 33'(CHUNK_BYTES - 1);
    assign chunks    = size_sum[32:CHUNK_SHIFT];
    assign alloc_bad = (chunks == '0) || (chunks > CHUNKS_W'(r_vacant));

    // A free is honored only for a nonzero address that falls in the region.
    assign offset     = r_req.address - r_base;
    assign free_chunk = offset[31:CHUNK_SHIFT];
    assign free_idx   = free_chunk[IDX_W-1:0];
    assign free_ok    = (r_req.address != 32'd0) && (r_req.address >= r_base) &&
                        ({1'b0, free_chunk} < (OFFS_W + 1)'(NUM_CHUNKS));

    // ------------------------------------------------------------------------
    // Scan step: one map entry per cycle
    // ------------------------------------------------------------------------
    // At a used entry the scan hops over the whole block; at a free entry it
    // extends the current run by one chunk. A block that reaches or runs past
    // the end of the region ends the scan without a fit, as does the last free chunk.
    logic [CNT_W-1:0] remain;
    logic [CNT_W-1:0] p_hop;
    logic [CNT_W-1:0] p_inc;
    logic [CNT_W-1:0] run_next;
    logic [IDX_W-1:0] run_start;
    logic [IDX_W-1:0] scan_next_p;
    logic             entry_used;
    logic             scan_fit;
    logic             scan_fail;

    assign entry_used  = (ram_rdata != '0);
    assign remain      = CNT_W'(NUM_CHUNKS) - CNT_W'(r_p);
    assign p_hop       = CNT_W'(r_p) + ram_rdata;
    assign p_inc       = CNT_W'(r_p) + CNT_W'(1);
    assign run_next    = r_run + CNT_W'(1);
    assign run_start   = IDX_W'(CNT_W'(r_p) - r_run);
    assign scan_next_p = entry_used ? p_hop[IDX_W-1:0] : p_inc[IDX_W-1:0];
    assign scan_fit    = !entry_used && (run_next == r_len);
    assign scan_fail   = entry_used ? (ram_rdata >= remain)
                                    : (!scan_fit && (p_inc == CNT_W'(NUM_CHUNKS)));

    // Length returned by a free, limited to what is actually occupied.
    logic [CNT_W-1:0] free_len;
    assign free_len = (ram_rdata > r_occupied) ? r_occupied : ram_rdata;

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == IDX_W'(NUM_CHUNKS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (r_req.operation == OP_ALLOC) begin
                    n_state = alloc_bad ? ST_EMIT : ST_SCAN;
                end else begin
                    n_state = free_ok ? ST_FREE : ST_EMIT;
                end
            end
            ST_SCAN: begin
                if (scan_fit || scan_fail) begin
                    n_state = ST_EMIT;
                end
            end
            ST_FREE: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // State outputs: handshake and map access
    // ------------------------------------------------------------------------
    always_comb begin
        o_in_stall = 1'b1;
        ram_we     = 1'b0;
        ram_waddr  = r_p;
        ram_wdata  = '0;
        ram_raddr  = r_p;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_DECODE: begin
                ram_raddr = (r_req.operation == OP_FREE) ? free_idx : '0;
            end
            ST_SCAN: begin
                ram_raddr = scan_next_p;
                if (scan_fit) begin
                    ram_we    = 1'b1;
                    ram_waddr = run_start;
                    ram_wdata = r_len;
                end
            end
            ST_FREE: begin
                ram_we = 1'b1;
            end
            ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_vacant    <= CNT_W'(NUM_CHUNKS);
            r_occupied  <= '0;
            r_base      <= BASE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            if (r_state == ST_SCAN && scan_fit) begin
                r_vacant   <= r_vacant - r_len;
                r_occupied <= r_occupied + r_len;
            end
            if (r_state == ST_FREE) begin
                r_vacant   <= r_vacant + free_len;
                r_occupied <= r_occupied - free_len;
            end
            if (r_state == ST_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_req <= i_in;
            end
            ST_DECODE: begin
                r_p          <= (r_req.operation == OP_FREE) ? free_idx : '0;
                r_run        <= '0;
                r_len        <= chunks[CNT_W-1:0];
                r_res_addr   <= 32'd0;
                r_res_status <= (r_req.operation == OP_ALLOC) ? STATUS_FAIL
                                                              : STATUS_IGNORED;
            end
            ST_SCAN: begin
                r_p   <= scan_next_p;
                r_run <= entry_used ? '0 : run_next;
                if (scan_fit) begin
                    r_res_addr   <= r_base + 32'({run_start, {CHUNK_SHIFT{1'b0}}});
                    r_res_status <= STATUS_DONE;
                end
            end
            ST_FREE: begin
                r_res_status <= STATUS_DONE;
            end
            ST_EMIT: begin
                if (out_free) begin
                    r_out.block_address  <= r_res_addr;
                    r_out.status         <= r_res_status;
                    r_out.vacant_bytes   <= BYTES_W'({r_vacant, {CHUNK_SHIFT{1'b0}}});
                    r_out.occupied_bytes <= BYTES_W'({r_occupied, {CHUNK_SHIFT{1'b0}}});
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ffca_ram.sv =====
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module ffca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
